// ===== rtl/core/lgs_pkg.sv =====
// Shared types, constants and the per-step servo write table of the gait sequencer.
// No dependencies; every other file imports this package.
package lgs_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int STEPS_PER_CYCLE = 7;
  localparam int STEP_W          = 3;
  localparam int MAX_WRITES      = 4;
  localparam int CNT_W           = 3;
  localparam int ID_W            = 4;
  localparam int POS_W           = 10;
  localparam int MODE_W          = 3;
  localparam int RULE_W          = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 10;

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(STEPS_PER_CYCLE);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_TURN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_LIMIT  = 3'd4;

  localparam logic [SAMPLE_W-1:0] NEAR_LOW_RST  = 10'd75;
  localparam logic [SAMPLE_W-1:0] NEAR_MID_RST  = 10'd100;
  localparam logic [SAMPLE_W-1:0] NEAR_HIGH_RST = 10'd180;
  localparam logic [SAMPLE_W-1:0] FAR_TURN_RST  = 10'd200;
  localparam logic [SAMPLE_W-1:0] IR_LIMIT_RST  = 10'd33;

  // classifier rule codes
  localparam logic [RULE_W-1:0] RULE_STRAIGHT_BAND = 4'd0;
  localparam logic [RULE_W-1:0] RULE_SLEFT_BAND    = 4'd1;
  localparam logic [RULE_W-1:0] RULE_SRIGHT_BAND   = 4'd2;
  localparam logic [RULE_W-1:0] RULE_FAR           = 4'd3;
  localparam logic [RULE_W-1:0] RULE_NEAR_FRONT    = 4'd4;
  localparam logic [RULE_W-1:0] RULE_TOO_NEAR      = 4'd5;
  localparam logic [RULE_W-1:0] RULE_FRONT_LEFT    = 4'd6;
  localparam logic [RULE_W-1:0] RULE_LEFT_ONLY     = 4'd7;
  localparam logic [RULE_W-1:0] RULE_DEFAULT       = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_STRAIGHT = 3'd0,
    MODE_SLEFT    = 3'd1,
    MODE_SRIGHT   = 3'd2,
    MODE_LEFT     = 3'd3,
    MODE_RIGHT    = 3'd4
  } gait_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] near_low;
    logic [SAMPLE_W-1:0] near_mid;
    logic [SAMPLE_W-1:0] near_high;
    logic [SAMPLE_W-1:0] far_turn;
    logic [SAMPLE_W-1:0] ir_limit;
  } thresh_t;

  typedef struct packed {
    gait_mode_t        mode;
    logic [RULE_W-1:0] rule;
  } class_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
  } servo_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    servo_wr_t [MAX_WRITES-1:0]      wr;
  } step_plan_t;

  function automatic servo_wr_t wr_of(input int unsigned id, input int unsigned pos);
    servo_wr_t w;
    w.id  = ID_W'(id);
    w.pos = POS_W'(pos);
    return w;
  endfunction

  // Servo writes for one step; entry 0 goes out first.
  function automatic step_plan_t step_plan(input gait_mode_t mode,
                                           input logic [STEP_W-1:0] step);
    step_plan_t  p;
    logic        left;
    int unsigned s2;
    int unsigned s9;
    p    = '0;
    left = (mode == MODE_LEFT);
    s2   = (mode == MODE_SLEFT) ? 700 : 670;
    s9   = (mode == MODE_SLEFT) ? 920 : ((mode == MODE_SRIGHT) ? 960 : 950);
    if (mode == MODE_LEFT || mode == MODE_RIGHT) begin
      unique case (step)
        3'd1: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(3, 590); p.wr[1] = wr_of(10, 270);
        end
        3'd2: begin
          p.cnt = 3'd2;
          p.wr[0] = wr_of(2, left ? 870 : 610); p.wr[1] = wr_of(8, left ? 870 : 610);
        end
        3'd3: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(3, 520); p.wr[1] = wr_of(10, 200);
        end
        3'd4: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(7, 760); p.wr[1] = wr_of(4, 750);
        end
        3'd5: begin
          p.cnt = 3'd2;
          p.wr[0] = wr_of(6, left ? 1020 : 760); p.wr[1] = wr_of(9, left ? 1020 : 760);
        end
        3'd6: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(7, 830); p.wr[1] = wr_of(4, 820);
        end
        default: begin
          p.cnt = 3'd4;
          p.wr[0] = wr_of(2, 750); p.wr[1] = wr_of(6, 900);
          p.wr[2] = wr_of(8, 730); p.wr[3] = wr_of(9, 900);
        end
      endcase
    end else begin
      unique case (step)
        3'd1: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(7, 760); p.wr[1] = wr_of(4, 750);
        end
        3'd2: begin
          p.cnt = 3'd4;
          p.wr[0] = wr_of(2, 810); p.wr[1] = wr_of(8, 670);
          p.wr[2] = wr_of(6, 960); p.wr[3] = wr_of(9, 820);
        end
        3'd3: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(7, 830); p.wr[1] = wr_of(4, 820);
        end
        3'd4: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(3, 590); p.wr[1] = wr_of(10, 270);
        end
        3'd5: begin
          p.cnt = 3'd4;
          p.wr[0] = wr_of(2, s2);  p.wr[1] = wr_of(8, 810);
          p.wr[2] = wr_of(6, 820); p.wr[3] = wr_of(9, s9);
        end
        3'd6: begin
          p.cnt = 3'd2; p.wr[0] = wr_of(3, 520); p.wr[1] = wr_of(10, 200);
        end
        default: begin
          // final step of the straight family moves nothing
          p.cnt = 3'd0;
        end
      endcase
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/lgs_in_if.sv =====
// Input channel of the gait sequencer: sensor samples and step ticks.
// Depends on lgs_pkg.
interface lgs_in_if import lgs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] dist_sample;
  logic [SAMPLE_W-1:0] front_sample;
  logic [SAMPLE_W-1:0] left_sample;

  modport source (output valid, action, dist_sample, front_sample, left_sample,
                  input ready);
  modport sink   (input valid, action, dist_sample, front_sample, left_sample,
                  output ready);
endinterface

// ===== rtl/core/lgs_out_if.sv =====
// Result channel of the gait sequencer: one servo goal write per transaction.
// Depends on lgs_pkg.
interface lgs_out_if import lgs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   servo_id;
  logic [POS_W-1:0]  goal_position;
  logic [MODE_W-1:0] mode_now;
  logic [RULE_W-1:0] rule_hit;
  logic              last_write;

  modport source (output valid, servo_id, goal_position, mode_now, rule_hit, last_write,
                  input ready);
  modport sink   (input valid, servo_id, goal_position, mode_now, rule_hit, last_write,
                  output ready);
endinterface

// ===== rtl/core/lgs_cfg_if.sv =====
// Configuration write channel of the gait sequencer: register index and data.
// Depends on lgs_pkg.
interface lgs_cfg_if import lgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/legged_gait_sequencer.sv =====
// Top level of the legged gait sequencer: sensor state, step counter, result buffer.
// Depends on lgs_pkg, lgs_in_if, lgs_out_if, lgs_cfg_if and lgs_classifier.
//
// Usage:
//   in_ch carries sample transactions (action 0: store distance, front and left
//   readings) and step ticks (action 1). A tick re-classifies the gait mode when
//   the previous cycle of 7 steps has finished, then loads that step's 0 to 4
//   servo goal writes into a 4-entry result buffer. out_ch drains the buffer one
//   write per cycle while out_ch.ready is high; last_write marks the final write
//   of the tick. cfg_ch writes the five threshold registers; it is always ready
//   and writes to an index beyond the list are dropped. Write it only while idle.
// Transaction flow:
//   The first write of a tick is valid the cycle after the tick is taken. A tick
//   with writes holds in_ch until its last write is taken (the buffer drain
//   through the single out_ch port sets this); samples and ticks with no write
//   are taken without holding in_ch. The next transaction is taken in the same
//   cycle that the last buffered write is taken.
// Reset: thresholds 75/100/180/200/33, readings zero, mode slight right, step 1,
//   cycle finished, buffer empty.
// Stall: while out_ch.ready is low the head write holds and in_ch.ready stays low.
module legged_gait_sequencer import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lgs_in_if.sink      in_ch,
  lgs_out_if.source   out_ch,
  lgs_cfg_if.sink     cfg_ch
);

  localparam int KEEP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << KEEP_W) - 1);

  thresh_t                    thr_r;
  logic [SAMPLE_W-1:0]        dist_r, front_r, left_r;
  gait_mode_t                 mode_r, mode_nxt;
  logic [RULE_W-1:0]          rule_r, rule_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       done_r, done_nxt;

  servo_wr_t [MAX_WRITES-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  gait_mode_t                 out_mode_r;
  logic [RULE_W-1:0]          out_rule_r;

  class_t                     cls;
  step_plan_t                 plan;
  logic [STEP_W-1:0]          step_eff;
  logic                       in_acc, tick_acc, sample_acc, pop, cfg_acc;

  lgs_classifier u_classifier (
    .thr     (thr_r),
    .dist_rd (dist_r),
    .front   (front_r),
    .left    (left_r),
    .cls     (cls)
  );

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.servo_id      = buf_r[0].id;
  assign out_ch.goal_position = buf_r[0].pos;
  assign out_ch.mode_now      = MODE_W'(out_mode_r);
  assign out_ch.rule_hit      = out_rule_r;
  assign out_ch.last_write    = (cnt_r == CNT_W'(1));
  assign pop                  = out_ch.valid && out_ch.ready;

  // take a new transaction once the buffer is empty or its last write leaves now
  assign in_ch.ready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick_acc    = in_acc && in_ch.action;
  assign sample_acc  = in_acc && !in_ch.action;

  // classify at the start of a walking cycle, else keep the running mode
  always_comb begin
    mode_nxt = mode_r;
    rule_nxt = rule_r;
    if (done_r) begin
      mode_nxt = cls.mode;
      rule_nxt = cls.rule;
    end
  end

  // out-of-range step codes act as the final step
  assign step_eff = (step_r < STEP_FIRST || step_r > STEP_LAST) ? STEP_LAST : step_r;
  assign plan     = step_plan(mode_nxt, step_eff);

  always_comb begin
    step_nxt = step_eff + STEP_W'(1);
    done_nxt = 1'b0;
    if (step_eff >= STEP_LAST) begin
      step_nxt = STEP_FIRST;
      done_nxt = 1'b1;
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (tick_acc) begin
      buf_nxt = plan.wr;
      cnt_nxt = plan.cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_WRITES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '{near_low: NEAR_LOW_RST, near_mid: NEAR_MID_RST,
                  near_high: NEAR_HIGH_RST, far_turn: FAR_TURN_RST,
                  ir_limit: IR_LIMIT_RST};
      dist_r <= '0;
      front_r <= '0;
      left_r <= '0;
      mode_r <= MODE_SRIGHT;
      rule_r <= RULE_STRAIGHT_BAND;
      step_r <= STEP_FIRST;
      done_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          CFG_NEAR_LOW:  thr_r.near_low  <= cfg_ch.data;
          CFG_NEAR_MID:  thr_r.near_mid  <= cfg_ch.data;
          CFG_NEAR_HIGH: thr_r.near_high <= cfg_ch.data;
          CFG_FAR_TURN:  thr_r.far_turn  <= cfg_ch.data;
          CFG_IR_LIMIT:  thr_r.ir_limit  <= cfg_ch.data;
          default: ;
        endcase
      end
      if (sample_acc) begin
        dist_r  <= in_ch.dist_sample & SAMPLE_MASK;
        front_r <= in_ch.front_sample & SAMPLE_MASK;
        left_r  <= in_ch.left_sample & SAMPLE_MASK;
      end
      if (tick_acc) begin
        mode_r <= mode_nxt;
        rule_r <= rule_nxt;
        step_r <= step_nxt;
        done_r <= done_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (tick_acc) begin
      out_mode_r <= mode_nxt;
      out_rule_r <= rule_nxt;
    end
  end

endmodule

// ===== rtl/core/lgs_classifier.sv =====
// Gait mode classifier: priority chain of strict compares on the stored readings.
// Depends on lgs_pkg.
module lgs_classifier import lgs_pkg::*; (
  input  thresh_t             thr,
  input  logic [SAMPLE_W-1:0] dist_rd,
  input  logic [SAMPLE_W-1:0] front,
  input  logic [SAMPLE_W-1:0] left,
  output class_t              cls
);

  logic front_clear;
  logic front_block;
  logic left_block;

  assign front_clear = front < thr.ir_limit;
  assign front_block = front > thr.ir_limit;
  assign left_block  = left > thr.ir_limit;

  // first match wins; a reading equal to a threshold falls through
  always_comb begin
    priority if (dist_rd > thr.near_mid && dist_rd < thr.near_high && front_clear) begin
      cls = '{mode: MODE_STRAIGHT, rule: RULE_STRAIGHT_BAND};
    end else if (dist_rd > thr.near_high && front_clear) begin
      cls = '{mode: MODE_SLEFT, rule: RULE_SLEFT_BAND};
    end else if (dist_rd > thr.near_low && dist_rd < thr.near_mid && front_clear) begin
      cls = '{mode: MODE_SRIGHT, rule: RULE_SRIGHT_BAND};
    end else if (dist_rd > thr.far_turn) begin
      cls = '{mode: MODE_LEFT, rule: RULE_FAR};
    end else if (dist_rd < thr.near_mid && front_block) begin
      cls = '{mode: MODE_RIGHT, rule: RULE_NEAR_FRONT};
    end else if (dist_rd < thr.near_low) begin
      cls = '{mode: MODE_RIGHT, rule: RULE_TOO_NEAR};
    end else if (front_block && left_block) begin
      cls = '{mode: MODE_RIGHT, rule: RULE_FRONT_LEFT};
    end else if (front_clear && left_block) begin
      cls = '{mode: MODE_SRIGHT, rule: RULE_LEFT_ONLY};
    end else begin
      cls = '{mode: MODE_STRAIGHT, rule: RULE_DEFAULT};
    end
  end

endmodule
